>>> rtl/core/qepd_pkg.sv
// Shared types and constants for the quadrature encoder period and direction meter.
`default_nettype none

package qepd_pkg;

  // Field widths
  localparam int TIME_W = 31;

  // Moving average: window length is a power of two so the average is a shift
  localparam int AVG_SHIFT = 3;
  localparam int AVG_LEN   = 1 << AVG_SHIFT;
  localparam int PTR_W     = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
  localparam int SUM_W     = TIME_W + AVG_SHIFT;

  // Stream payload widths, tdata padded to whole bytes
  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 64;
  localparam int M_USER_W = 1;

  // Saturated period for equal timestamps
  localparam logic [TIME_W-1:0] PERIOD_MAX = {TIME_W{1'b1}};

  // Event codes
  typedef enum logic [1:0] {
    CMD_EDGE_V = 2'd0,
    CMD_EDGE_W = 2'd1,
    CMD_STALL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef logic [TIME_W-1:0] time_t;

endpackage

`default_nettype wire

>>> rtl/core/quad_encoder_period_direction.sv
// Quadrature encoder period, moving average and direction meter.
//
//   channel  dir  tdata (low bit up)                          tuser
//   s_*      in   capture_time[30:0] level_v level_w pad[6:0] cmd[1:0]
//   m_*      out  period[30:0] period_average[30:0] direction period_updated
//
// The event is decoded and the state and result register
// update at the accepting edge; the result appears on m_* in the next cycle.
// The single result register sets the rate: a new item is taken every cycle
// while the result is consumed in that same cycle (s_tready = !m_tvalid | m_tready).
// Synchronous reset clears the measurement state but the sample window array, and empties the result register.
// A stalled result holds m_* and back-pressures s_*; no item is dropped.
`default_nettype none

module quad_encoder_period_direction (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // capture_time[30:0], level_v[31], level_w[32], zero pad [39:33]
  input  wire  [qepd_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  wire  [qepd_pkg::S_USER_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // period[30:0], period_average[61:31], direction[62], zero pad [63]
  output logic [qepd_pkg::M_DATA_W-1:0] m_tdata,
  // period_updated[0]
  output logic [qepd_pkg::M_USER_W-1:0] m_tuser
);
  import qepd_pkg::*;

  // Measurement state
  time_t             last_capture;
  logic              have_capture;
  logic              last_v;
  logic              last_w;
  logic              rotation;
  time_t             held_period;
  time_t             held_average;
  time_t             window [AVG_LEN];
  logic [SUM_W-1:0]  window_sum;
  logic [PTR_W-1:0]  window_pointer;
  logic              window_primed;

  // Next values
  time_t             last_capture_next;
  logic              have_capture_next;
  logic              last_v_next;
  logic              last_w_next;
  logic              rotation_next;
  time_t             held_period_next;
  time_t             held_average_next;
  logic [SUM_W-1:0]  window_sum_next;
  logic [PTR_W-1:0]  window_pointer_next;
  logic              window_primed_next;
  logic              updated;

  // Unpacked input item
  cmd_t   cmd;
  time_t  capture_time;
  logic   level_v;
  logic   level_w;
  logic   accept;
  logic   prior;
  time_t  delta;
  time_t  sample;
  logic [SUM_W-1:0] sum_step;

  assign cmd          = cmd_t'(s_tuser[1:0]);
  assign capture_time = s_tdata[TIME_W-1:0];
  assign level_v      = s_tdata[TIME_W];
  assign level_w      = s_tdata[TIME_W+1];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Period since the previous capture, saturated when timestamps match
  assign prior  = have_capture && (last_capture != '0);
  assign delta  = capture_time - last_capture;
  assign sample = (delta == '0) ? PERIOD_MAX : delta;
  assign sum_step = window_sum - SUM_W'(window[window_pointer]) + SUM_W'(sample);

  // Decode the event and form the next state
  always_comb begin
    last_capture_next   = last_capture;
    have_capture_next   = have_capture;
    last_v_next         = last_v;
    last_w_next         = last_w;
    rotation_next       = rotation;
    held_period_next    = held_period;
    held_average_next   = held_average;
    window_sum_next     = window_sum;
    window_pointer_next = window_pointer;
    window_primed_next  = window_primed;
    updated             = 1'b0;
    case (cmd)
      CMD_EDGE_V, CMD_EDGE_W: begin
        if (prior) begin
          if (cmd == CMD_EDGE_V) begin
            rotation_next = (level_v == last_w);
          end else begin
            rotation_next = (level_w != last_v);
          end
          held_period_next = sample;
          updated          = 1'b1;
          if (!window_primed) begin
            window_sum_next     = SUM_W'(sample) << AVG_SHIFT;
            window_pointer_next = '0;
            window_primed_next  = 1'b1;
            held_average_next   = sample;
          end else begin
            window_sum_next     = sum_step;
            window_pointer_next = (window_pointer == PTR_W'(AVG_LEN - 1)) ?
                                  '0 : window_pointer + 1'b1;
            held_average_next   = TIME_W'(sum_step >> AVG_SHIFT);
          end
        end
        last_v_next       = level_v;
        last_w_next       = level_w;
        last_capture_next = capture_time;
        have_capture_next = 1'b1;
      end
      CMD_STALL: begin
        window_sum_next     = '0;
        window_pointer_next = '0;
        window_primed_next  = 1'b0;
        last_capture_next   = '0;
        have_capture_next   = 1'b0;
        held_period_next    = '0;
        held_average_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // Advance control state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture   <= '0;
      have_capture   <= 1'b0;
      last_v         <= 1'b0;
      last_w         <= 1'b0;
      rotation       <= 1'b0;
      held_period    <= '0;
      held_average   <= '0;
      window_sum     <= '0;
      window_pointer <= '0;
      window_primed  <= 1'b0;
    end else if (accept) begin
      last_capture   <= last_capture_next;
      have_capture   <= have_capture_next;
      last_v         <= last_v_next;
      last_w         <= last_w_next;
      rotation       <= rotation_next;
      held_period    <= held_period_next;
      held_average   <= held_average_next;
      window_sum     <= window_sum_next;
      window_pointer <= window_pointer_next;
      window_primed  <= window_primed_next;
    end
  end

  // Write the sample window: fill every entry on the first sample, else one slot
  always_ff @(posedge clk) begin
    if (accept && updated) begin
      if (!window_primed) begin
        for (int i = 0; i < AVG_LEN; i++) begin
          window[i] <= sample;
        end
      end else begin
        window[window_pointer] <= sample;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, rotation_next, held_average_next, held_period_next};
      m_tuser <= updated;
    end
  end

`ifndef ASSERT_OFF
  // A stall leaves the filter empty and the period cleared
  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_STALL) |=> !window_primed && (held_period == '0)
                                     && !have_capture)
    else $error("stall did not clear the measurement");

  // An accepted item always yields a result
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

  // A reported new sample implies the filter holds data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> window_primed && (m_tdata[TIME_W-1:0] != '0))
    else $error("updated result without primed filter");

  // Without a previous capture the period is cleared
  assert property (@(posedge clk) disable iff (rst)
    !have_capture |-> (held_period == '0) && (held_average == '0))
    else $error("period held without a capture");
`endif

endmodule

`default_nettype wire

>>> bench/quad_encoder_period_direction_test.sv
// Self-checking stream testbench for the quadrature encoder period and direction meter.
`timescale 1ns / 1ps

module quad_encoder_period_direction_test;
  import qepd_pkg::*;

  localparam int WINDOW_BITS = AVG_SHIFT;
  localparam int WINDOW_LEN  = 1 << WINDOW_BITS;
  localparam time_t SPAN_SAT = {TIME_W{1'b1}};
  localparam int IDLE_PCT    = 12;

  typedef struct packed {
    cmd_t  cmd;
    time_t stamp;
    logic  lv;
    logic  lw;
  } encoder_event_t;

  typedef struct packed {
    time_t period;
    time_t average;
    logic  ccw;
    logic  fresh;
  } meter_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  encoder_event_t pending_events[$];
  meter_reading_t expected_readings[$];
  logic took_item = 1'b0;
  int loaded = 0;
  int faults = 0;

  // Meter state mirror
  time_t prev_stamp = '0;
  logic stamp_known = 1'b0;
  logic prev_v = 1'b0;
  logic prev_w = 1'b0;
  logic spin_ccw = 1'b0;
  time_t held_span = '0;
  time_t held_mean = '0;
  time_t span_window [WINDOW_LEN];
  logic [TIME_W+WINDOW_BITS-1:0] window_total = '0;
  logic [WINDOW_BITS-1:0] slot = '0;
  logic window_full = 1'b0;

  quad_encoder_period_direction DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Advance the meter mirror by one event and return the reading it shows
  task automatic measure_event(input encoder_event_t ev, output meter_reading_t r);
    time_t span;
    logic fresh;
    fresh = 1'b0;
    if (ev.cmd == CMD_EDGE_V || ev.cmd == CMD_EDGE_W) begin
      if (stamp_known && prev_stamp != '0) begin
        span = ev.stamp - prev_stamp;
        if (span == '0) span = SPAN_SAT;
        if (ev.cmd == CMD_EDGE_V) spin_ccw = (ev.lv == prev_w);
        else spin_ccw = (ev.lw != prev_v);
        held_span = span;
        if (!window_full) begin
          // first sample primes the whole window
          for (int i = 0; i < WINDOW_LEN; i++) span_window[i] = span;
          window_total = {{WINDOW_BITS{1'b0}}, span} << WINDOW_BITS;
          slot = '0;
          window_full = 1'b1;
          held_mean = span;
        end else begin
          window_total = window_total - span_window[slot] + span;
          span_window[slot] = span;
          slot = slot + 1'b1;
          held_mean = time_t'(window_total >> WINDOW_BITS);
        end
        fresh = 1'b1;
      end
      prev_v = ev.lv;
      prev_w = ev.lw;
      prev_stamp = ev.stamp;
      stamp_known = 1'b1;
    end else if (ev.cmd == CMD_STALL) begin
      // drop the measurement but keep direction and levels
      for (int i = 0; i < WINDOW_LEN; i++) span_window[i] = '0;
      window_total = '0;
      slot = '0;
      window_full = 1'b0;
      prev_stamp = '0;
      stamp_known = 1'b0;
      held_span = '0;
      held_mean = '0;
    end
    r.period = held_span;
    r.average = held_mean;
    r.ccw = spin_ccw;
    r.fresh = fresh;
  endtask

  task automatic flag_fault(input string what, input longint unsigned want,
                            input longint unsigned got);
    if (faults < 10)
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    faults++;
  endtask

  task automatic queue_event(input cmd_t c, input time_t t, input logic v, input logic w);
    encoder_event_t ev;
    ev.cmd = c;
    ev.stamp = t;
    ev.lv = v;
    ev.lw = w;
    pending_events.push_back(ev);
  endtask

  // Check results, then predict from the accepted item
  always @(posedge clk) begin : watch
    meter_reading_t want;
    meter_reading_t seen;
    encoder_event_t ev;
    if (!rst && m_tvalid && m_tready) begin
      seen.period = m_tdata[30:0];
      seen.average = m_tdata[61:31];
      seen.ccw = m_tdata[62];
      seen.fresh = m_tuser[0];
      if (expected_readings.size() == 0) begin
        flag_fault("unexpected result", 0, m_tdata);
      end else begin
        want = expected_readings.pop_front();
        if (seen.period != want.period) flag_fault("period", want.period, seen.period);
        if (seen.average != want.average) flag_fault("period_average", want.average, seen.average);
        if (seen.ccw != want.ccw) flag_fault("direction", want.ccw, seen.ccw);
        if (seen.fresh != want.fresh) flag_fault("period_updated", want.fresh, seen.fresh);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      ev.cmd = cmd_t'(s_tuser);
      ev.stamp = s_tdata[30:0];
      ev.lv = s_tdata[31];
      ev.lw = s_tdata[32];
      measure_event(ev, want);
      expected_readings.push_back(want);
    end
    took_item <= !rst && s_tvalid && s_tready;
  end

  // Present items and back-pressure at the falling edge
  always @(negedge clk) begin : drive
    encoder_event_t ev;
    logic [S_DATA_W-1:0] word;
    logic calm;
    calm = (loaded >= 500 && loaded < 800);
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || took_item) begin
        if (pending_events.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          ev = pending_events.pop_front();
          word = '0;
          word[30:0] = ev.stamp;
          word[31] = ev.lv;
          word[32] = ev.lw;
          s_tdata <= word;
          s_tuser <= ev.cmd;
          s_tvalid <= 1'b1;
          loaded++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    time_t stamp;
    logic [1:0] phase;
    logic [1:0] before_code;
    logic [1:0] after_code;
    logic fwd;
    int burst;
    int pick;
    time_t step;
    cmd_t c;

    // Directed: zero capture, saturation, wrap, unused command, stall
    queue_event(CMD_EDGE_V, 31'd0, 1'b1, 1'b0);
    queue_event(CMD_EDGE_W, 31'd100, 1'b1, 1'b1);
    queue_event(CMD_EDGE_V, 31'd400, 1'b0, 1'b1);
    queue_event(CMD_EDGE_W, 31'd400, 1'b0, 1'b0);
    queue_event(CMD_EDGE_V, 31'h7FFF_FFFF, 1'b1, 1'b0);
    queue_event(CMD_EDGE_W, 31'd5, 1'b1, 1'b1);
    queue_event(CMD_NONE, 31'h5555_5555, 1'b1, 1'b1);
    queue_event(CMD_EDGE_V, 31'd0, 1'b0, 1'b1);
    queue_event(CMD_EDGE_W, 31'd50, 1'b0, 1'b0);
    queue_event(CMD_EDGE_V, 31'd90, 1'b1, 1'b0);
    queue_event(CMD_STALL, 31'h2AAA_AAAA, 1'b1, 1'b1);
    queue_event(CMD_NONE, 31'd0, 1'b0, 1'b0);
    queue_event(CMD_EDGE_V, 31'd1000, 1'b0, 1'b0);
    queue_event(CMD_EDGE_W, 31'd999, 1'b0, 1'b1);
    queue_event(CMD_EDGE_V, 31'd1999, 1'b1, 1'b1);
    queue_event(CMD_EDGE_W, 31'd2999, 1'b1, 1'b0);
    queue_event(CMD_STALL, 31'd0, 1'b0, 1'b0);
    queue_event(CMD_STALL, 31'h7FFF_FFFF, 1'b1, 1'b0);
    queue_event(CMD_EDGE_W, 31'h7FFF_FFFF, 1'b1, 1'b1);
    queue_event(CMD_EDGE_V, 31'h7FFF_FFFF, 1'b0, 1'b1);

    // Random: mostly clean quadrature runs, some noise and glitches
    while (pending_events.size() < 1220) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        queue_event(cmd_t'(2'($urandom_range(3))), time_t'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(1))
          queue_event(CMD_STALL, time_t'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        if ($urandom_range(9) == 0) stamp = 31'h7FFF_FF00 + time_t'($urandom_range(255));
        else stamp = time_t'($urandom);
        fwd = 1'($urandom_range(1));
        phase = 2'($urandom_range(3));
        burst = $urandom_range(4, 30);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(15) == 0) fwd = !fwd;
          before_code = {phase[1], phase[1] ^ phase[0]};
          if ($urandom_range(19) == 0) begin
            // glitch: edge reported with no level change
            c = $urandom_range(1) ? CMD_EDGE_W : CMD_EDGE_V;
          end else begin
            phase = fwd ? phase + 2'd1 : phase - 2'd1;
            after_code = {phase[1], phase[1] ^ phase[0]};
            c = ((before_code ^ after_code) == 2'b01) ? CMD_EDGE_V : CMD_EDGE_W;
          end
          case ($urandom_range(19))
            0: step = '0;
            1: step = time_t'($urandom);
            default: step = time_t'($urandom_range(1, 5000));
          endcase
          stamp = stamp + step;
          queue_event(c, stamp, phase[1] ^ phase[0], phase[1]);
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Drain the stream, then let the pipeline settle
    while (pending_events.size() != 0 || s_tvalid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0 && expected_readings.size() == 0) begin
      $display("PASS quad_encoder_period_direction");
    end else begin
      $display("FAIL quad_encoder_period_direction");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(2_000_000);
    $display("FAIL quad_encoder_period_direction");
    $finish;
  end

endmodule
